FILE: rtl/e2q_pkg.sv
// shared types, constants and the arctangent table for the euler to quaternion datapath
// no dependencies
package e2q_pkg;

	// default configuration
	localparam int ANGLE_BITS_DEF  = 16;
	localparam int RESULT_BITS_DEF = 16;
	localparam int SINCOS_ITER_DEF = 16;

	// fixed internal formats
	localparam int CORDIC_FRAC = 40;
	localparam int TRIG_FRAC   = 30;
	localparam int XY_W        = 43;
	localparam int Z_W         = 36;
	localparam int TRIG_W      = 32;
	localparam int PROD_W      = 64;

	// cordic start vector, 0.6072529... in Q40
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 43'sd667681663043;

	// angle lane indexes
	localparam int ROLL_IDX  = 0;
	localparam int PITCH_IDX = 1;
	localparam int YAW_IDX   = 2;

	// one rotation lane: vector and residual angle
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} rot_t;

	// roll, pitch and yaw lanes travelling together
	typedef rot_t [2:0] rot3_t;

	// atan(2^-step) with a full turn equal to 2^34
	function automatic logic signed [Z_W-1:0] atan_step(input int unsigned step);
		logic [31:0] t;
		case (step)
			0:  t = 32'd536870912;
			1:  t = 32'd316933406;
			2:  t = 32'd167458907;
			3:  t = 32'd85004756;
			4:  t = 32'd42667331;
			5:  t = 32'd21354465;
			6:  t = 32'd10679838;
			7:  t = 32'd5340245;
			8:  t = 32'd2670163;
			9:  t = 32'd1335087;
			10: t = 32'd667544;
			11: t = 32'd333772;
			12: t = 32'd166886;
			13: t = 32'd83443;
			14: t = 32'd41722;
			15: t = 32'd20861;
			16: t = 32'd10430;
			17: t = 32'd5215;
			18: t = 32'd2608;
			19: t = 32'd1304;
			20: t = 32'd652;
			21: t = 32'd326;
			22: t = 32'd163;
			23: t = 32'd81;
			24: t = 32'd41;
			25: t = 32'd20;
			26: t = 32'd10;
			27: t = 32'd5;
			28: t = 32'd3;
			29: t = 32'd1;
			30: t = 32'd1;
			default: t = 32'd0;
		endcase
		return Z_W'({t, 2'b00});
	endfunction

endpackage

FILE: rtl/euler_to_quaternion.sv
// euler (z-y-x) angles to unit quaternion: a row of cordic cells then a multiply pipeline
// an accepted beat is registered in each cordic cell in turn, then in combine stages s1 to s5
// throughput: one beat per cycle if unstalled, set by the one-step-per-cell cordic chain
// a stalled output holds only the stages behind it until a bubble is reached
// reset: asynchronous, active low, empties every stage; no state beyond pipeline contents
module euler_to_quaternion #(
	parameter int ANGLE_BITS        = e2q_pkg::ANGLE_BITS_DEF,
	parameter int RESULT_BITS       = e2q_pkg::RESULT_BITS_DEF,
	parameter int SINCOS_ITERATIONS = e2q_pkg::SINCOS_ITER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [ANGLE_BITS-1:0]  roll_angle,
	input  logic signed [ANGLE_BITS-1:0]  pitch_angle,
	input  logic signed [ANGLE_BITS-1:0]  yaw_angle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [RESULT_BITS-1:0] quat_w,
	output logic signed [RESULT_BITS-1:0] quat_x,
	output logic signed [RESULT_BITS-1:0] quat_y,
	output logic signed [RESULT_BITS-1:0] quat_z
);
	import e2q_pkg::*;

	localparam int N    = SINCOS_ITERATIONS;
	localparam int Z_SH = 33 - ANGLE_BITS;

	logic signed [ANGLE_BITS-1:0] angle [0:2];
	logic  chain_valid [0:N];
	logic  chain_ready [0:N];
	rot3_t chain_data  [0:N];

	assign angle[ROLL_IDX]  = roll_angle;
	assign angle[PITCH_IDX] = pitch_angle;
	assign angle[YAW_IDX]   = yaw_angle;

	// chain head: half angle scaled into the accumulator, vector at the gain
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			chain_data[0][k].x = CORDIC_GAIN;
			chain_data[0][k].y = '0;
			chain_data[0][k].z = Z_W'(angle[k]) <<< Z_SH;
		end
	end

	assign chain_valid[0] = in_valid;
	assign in_stall       = !chain_ready[0];

	// cordic cells, one rotation step each
	for (genvar i = 0; i < N; i++) begin : g_cell
		e2q_cordic_cell #(
			.STEP(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(chain_valid[i]),
			.up_data (chain_data[i]),
			.up_ready(chain_ready[i]),
			.dn_valid(chain_valid[i+1]),
			.dn_data (chain_data[i+1]),
			.dn_ready(chain_ready[i+1])
		);
	end

	// products, sums and output register
	e2q_combine #(
		.RESULT_BITS(RESULT_BITS)
	) u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_valid[N]),
		.up_data  (chain_data[N]),
		.up_ready (chain_ready[N]),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.quat_w   (quat_w),
		.quat_x   (quat_x),
		.quat_y   (quat_y),
		.quat_z   (quat_z)
	);

`ifndef SYNTHESIS
	localparam logic signed [RESULT_BITS-1:0] MIN_Q = {1'b1, {(RESULT_BITS-1){1'b0}}};

	// saturation is symmetric, the most negative code never leaves
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (quat_w != MIN_Q && quat_x != MIN_Q && quat_y != MIN_Q && quat_z != MIN_Q))
		else $error("quaternion part at the most negative code");

	// an unstalled output lets every stage move, so the input never stalls
	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output flows");

	// input stall only with the first cell occupied
	a_stall_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> chain_valid[1])
		else $error("input stalled with empty first cell");
`endif

endmodule

FILE: rtl/e2q_cordic_cell.sv
// one cordic rotation step for the roll, pitch and yaw lanes, with its stage register
// depends on e2q_pkg
module e2q_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	input  e2q_pkg::rot3_t up_data,
	output logic          up_ready,
	output logic          dn_valid,
	output e2q_pkg::rot3_t dn_data,
	input  logic          dn_ready
);
	import e2q_pkg::*;

	localparam logic signed [Z_W-1:0] DA = atan_step(STEP);

	logic  valid_q;
	rot3_t data_q;
	rot3_t next_data;

	// stage takes a beat when empty or when its content moves on
	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	// micro-rotation, direction from the sign of the residual angle
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (!up_data[k].z[Z_W-1]) begin
				next_data[k].x = up_data[k].x - (up_data[k].y >>> STEP);
				next_data[k].y = up_data[k].y + (up_data[k].x >>> STEP);
				next_data[k].z = up_data[k].z - DA;
			end else begin
				next_data[k].x = up_data[k].x + (up_data[k].y >>> STEP);
				next_data[k].y = up_data[k].y - (up_data[k].x >>> STEP);
				next_data[k].z = up_data[k].z + DA;
			end
		end
	end

	// stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= next_data;
		end
	end

endmodule

FILE: rtl/e2q_combine.sv
// rounds the cordic outputs and forms the quaternion through two multiply levels
// depends on e2q_pkg
module e2q_combine #(
	parameter int RESULT_BITS = e2q_pkg::RESULT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	input  e2q_pkg::rot3_t                up_data,
	output logic                          up_ready,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [RESULT_BITS-1:0] quat_w,
	output logic signed [RESULT_BITS-1:0] quat_x,
	output logic signed [RESULT_BITS-1:0] quat_y,
	output logic signed [RESULT_BITS-1:0] quat_z
);
	import e2q_pkg::*;

	localparam int TRIG_SH = CORDIC_FRAC - TRIG_FRAC;
	localparam int RES_SH  = 2 * TRIG_FRAC - (RESULT_BITS - 1);
	localparam logic signed [XY_W-1:0]   RND_TRIG = XY_W'(1) <<< (TRIG_SH - 1);
	localparam logic signed [PROD_W-1:0] RND_PAIR = PROD_W'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [PROD_W-1:0] RND_RES  = PROD_W'(1) <<< (RES_SH - 1);
	localparam logic signed [PROD_W-1:0] LIM      = (PROD_W'(1) <<< (RESULT_BITS - 1)) - PROD_W'(1);

	// round half up to the result scale and clamp symmetric
	function automatic logic signed [RESULT_BITS-1:0] to_result(
		input logic signed [PROD_W-1:0] v
	);
		logic signed [PROD_W-1:0] r;
		r = (v + RND_RES) >>> RES_SH;
		if (r > LIM) begin
			r = LIM;
		end else if (r < -LIM) begin
			r = -LIM;
		end
		return r[RESULT_BITS-1:0];
	endfunction

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic signed [TRIG_W-1:0] cos_s1 [0:2];
	logic signed [TRIG_W-1:0] sin_s1 [0:2];

	logic signed [PROD_W-1:0] crcp_s2, srsp_s2, srcp_s2, crsp_s2;
	logic signed [TRIG_W-1:0] cy_s2, sy_s2;

	logic signed [TRIG_W-1:0] crcp_s3, srsp_s3, srcp_s3, crsp_s3;
	logic signed [TRIG_W-1:0] cy_s3, sy_s3;

	logic signed [PROD_W-1:0] wa_s4, wb_s4, xa_s4, xb_s4, ya_s4, yb_s4, za_s4, zb_s4;

	logic signed [RESULT_BITS-1:0] quat_w_s5, quat_x_s5, quat_y_s5, quat_z_s5;

	// per-stage ready, a bubble anywhere lets the stages before it move
	assign rdy_s5   = !valid_s5 || !out_stall;
	assign rdy_s4   = !valid_s4 || rdy_s5;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign up_ready = !valid_s1 || rdy_s2;

	// stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (up_ready) valid_s1 <= up_valid;
			if (rdy_s2)   valid_s2 <= valid_s1;
			if (rdy_s3)   valid_s3 <= valid_s2;
			if (rdy_s4)   valid_s4 <= valid_s3;
			if (rdy_s5)   valid_s5 <= valid_s4;
		end
	end

	// s1: cosine and sine rounded to q30
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			for (int k = 0; k < 3; k++) begin
				cos_s1[k] <= TRIG_W'((up_data[k].x + RND_TRIG) >>> TRIG_SH);
				sin_s1[k] <= TRIG_W'((up_data[k].y + RND_TRIG) >>> TRIG_SH);
			end
		end
	end

	// s2: roll by pitch products
	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			crcp_s2 <= cos_s1[ROLL_IDX] * cos_s1[PITCH_IDX];
			srsp_s2 <= sin_s1[ROLL_IDX] * sin_s1[PITCH_IDX];
			srcp_s2 <= sin_s1[ROLL_IDX] * cos_s1[PITCH_IDX];
			crsp_s2 <= cos_s1[ROLL_IDX] * sin_s1[PITCH_IDX];
			cy_s2   <= cos_s1[YAW_IDX];
			sy_s2   <= sin_s1[YAW_IDX];
		end
	end

	// s3: pair products back to q30
	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			crcp_s3 <= TRIG_W'((crcp_s2 + RND_PAIR) >>> TRIG_FRAC);
			srsp_s3 <= TRIG_W'((srsp_s2 + RND_PAIR) >>> TRIG_FRAC);
			srcp_s3 <= TRIG_W'((srcp_s2 + RND_PAIR) >>> TRIG_FRAC);
			crsp_s3 <= TRIG_W'((crsp_s2 + RND_PAIR) >>> TRIG_FRAC);
			cy_s3   <= cy_s2;
			sy_s3   <= sy_s2;
		end
	end

	// s4: products with the yaw terms, q60
	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			wa_s4 <= crcp_s3 * cy_s3;
			wb_s4 <= srsp_s3 * sy_s3;
			xa_s4 <= srcp_s3 * cy_s3;
			xb_s4 <= crsp_s3 * sy_s3;
			ya_s4 <= crsp_s3 * cy_s3;
			yb_s4 <= srcp_s3 * sy_s3;
			za_s4 <= crcp_s3 * sy_s3;
			zb_s4 <= srsp_s3 * cy_s3;
		end
	end

	// s5: exact sums, rounding and saturation into the output register
	always_ff @(posedge clk) begin
		if (rdy_s5 && valid_s4) begin
			quat_w_s5 <= to_result(wa_s4 + wb_s4);
			quat_x_s5 <= to_result(xa_s4 - xb_s4);
			quat_y_s5 <= to_result(ya_s4 + yb_s4);
			quat_z_s5 <= to_result(za_s4 - zb_s4);
		end
	end

	assign out_valid = valid_s5;
	assign quat_w    = quat_w_s5;
	assign quat_x    = quat_x_s5;
	assign quat_y    = quat_y_s5;
	assign quat_z    = quat_z_s5;

endmodule

FILE: sim/euler_to_quaternion_check.sv
`timescale 1ns / 1ps
// channel monitor and scoreboard for euler_to_quaternion: predicts each quaternion from the angles
// depends on e2q_pkg for the default widths, iteration count and fraction formats
module euler_to_quaternion_check (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	input  logic                                       in_stall,
	input  logic signed [e2q_pkg::ANGLE_BITS_DEF-1:0]  roll_angle,
	input  logic signed [e2q_pkg::ANGLE_BITS_DEF-1:0]  pitch_angle,
	input  logic signed [e2q_pkg::ANGLE_BITS_DEF-1:0]  yaw_angle,
	input  logic                                       out_valid,
	input  logic                                       out_stall,
	input  logic signed [e2q_pkg::RESULT_BITS_DEF-1:0] quat_w,
	input  logic signed [e2q_pkg::RESULT_BITS_DEF-1:0] quat_x,
	input  logic signed [e2q_pkg::RESULT_BITS_DEF-1:0] quat_y,
	input  logic signed [e2q_pkg::RESULT_BITS_DEF-1:0] quat_z,
	output int                                         errors,
	output int                                         pending,
	output int                                         checked
);

	localparam int ABITS = e2q_pkg::ANGLE_BITS_DEF;
	localparam int RBITS = e2q_pkg::RESULT_BITS_DEF;
	localparam int ITERS = e2q_pkg::SINCOS_ITER_DEF;
	localparam int QFRAC = e2q_pkg::TRIG_FRAC;
	localparam longint SAT_MAX = (longint'(1) <<< (RBITS - 1)) - 1;

	// arctangent steps, full turn = 2^32 before the x4 scaling
	localparam longint ATAN_TURN [0:31] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245,
		2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304,
		652, 326, 163, 81,
		41, 20, 10, 5,
		3, 1, 1, 0
	};

	typedef struct packed {
		logic signed [RBITS-1:0] w;
		logic signed [RBITS-1:0] x;
		logic signed [RBITS-1:0] y;
		logic signed [RBITS-1:0] z;
	} quat_t;

	quat_t expected_quats [$];

	// round half up while dropping sh fraction bits
	function automatic longint round_off(input longint v, input int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	// cosine and sine of half the binary angle, q30, by rotation-mode cordic
	function automatic void half_angle_trig(input logic signed [ABITS-1:0] a,
			output longint c, output longint s);
		longint vx, vy, resid, dx, dy, step_ang;
		vx = 64'sd667681663043;
		vy = 0;
		resid = longint'(a) <<< (33 - ABITS);
		for (int i = 0; i < ITERS; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			step_ang = ATAN_TURN[i] * 4;
			if (resid >= 0) begin
				vx -= dx;
				vy += dy;
				resid -= step_ang;
			end else begin
				vx += dx;
				vy -= dy;
				resid += step_ang;
			end
		end
		c = round_off(vx, e2q_pkg::CORDIC_FRAC - QFRAC);
		s = round_off(vy, e2q_pkg::CORDIC_FRAC - QFRAC);
	endfunction

	// q60 sum down to a saturated q1.15 part
	function automatic logic signed [RBITS-1:0] to_q15(input longint q60);
		longint v;
		v = round_off(q60, 2 * QFRAC - (RBITS - 1));
		if (v > SAT_MAX)
			v = SAT_MAX;
		if (v < -SAT_MAX)
			v = -SAT_MAX;
		return RBITS'(v);
	endfunction

	function automatic quat_t zyx_quaternion(input logic signed [ABITS-1:0] r,
			input logic signed [ABITS-1:0] p, input logic signed [ABITS-1:0] yw);
		longint cr, sr, cp, sp, cy, sy;
		longint crcp, srsp, srcp, crsp;
		quat_t q;
		half_angle_trig(r, cr, sr);
		half_angle_trig(p, cp, sp);
		half_angle_trig(yw, cy, sy);
		crcp = round_off(cr * cp, QFRAC);
		srsp = round_off(sr * sp, QFRAC);
		srcp = round_off(sr * cp, QFRAC);
		crsp = round_off(cr * sp, QFRAC);
		q.w = to_q15(crcp * cy + srsp * sy);
		q.x = to_q15(srcp * cy - crsp * sy);
		q.y = to_q15(crsp * cy + srcp * sy);
		q.z = to_q15(crcp * sy - srsp * cy);
		return q;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
	end

	// result beats first, then new angle beats; latency keeps them apart
	always @(posedge clk) begin
		quat_t want;
		quat_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{w: quat_w, x: quat_x, y: quat_y, z: quat_z};
				if (expected_quats.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result beat w=%0d x=%0d y=%0d z=%0d",
							$realtime, got.w, got.x, got.y, got.z);
				end else begin
					want = expected_quats.pop_front();
					checked++;
					if (got.w !== want.w || got.x !== want.x || got.y !== want.y
							|| got.z !== want.z) begin
						errors++;
						if (errors <= 10)
							$display("%0t: quaternion mismatch exp w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
								$realtime, want.w, want.x, want.y, want.z,
								got.w, got.x, got.y, got.z);
					end
				end
			end
			if (in_valid && !in_stall)
				expected_quats.push_back(zyx_quaternion(roll_angle, pitch_angle, yaw_angle));
			pending <= expected_quats.size();
		end
	end

endmodule

FILE: sim/euler_to_quaternion_test.sv
`timescale 1ns / 1ps
// top of the euler_to_quaternion testbench: clock, reset, angle stimulus and verdict
// depends on e2q_pkg, the block itself and euler_to_quaternion_check
module euler_to_quaternion_test;

	localparam int ABITS = e2q_pkg::ANGLE_BITS_DEF;
	localparam int RBITS = e2q_pkg::RESULT_BITS_DEF;
	localparam int RANDOM_BEATS = 650;
	localparam int DRAIN_CYCLES = 40;

	// directed angle triples: zero, extremes, quarter turns, gimbal lock, bit patterns
	localparam int DIRECTED = 21;
	localparam logic [15:0] DIR_ROLL  [DIRECTED] = '{
		16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000,
		16'h8000, 16'h7fff, 16'h4000, 16'h0000, 16'h0000, 16'hc000, 16'h0001,
		16'h4000, 16'h1234, 16'h5555, 16'haaaa, 16'h8000, 16'h2000, 16'hffff
	};
	localparam logic [15:0] DIR_PITCH [DIRECTED] = '{
		16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000,
		16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'h0000, 16'hc000, 16'hffff,
		16'h4000, 16'h4000, 16'haaaa, 16'h5555, 16'h7fff, 16'he000, 16'h0001
	};
	localparam logic [15:0] DIR_YAW   [DIRECTED] = '{
		16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h7fff,
		16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h4000, 16'hc000, 16'h0001,
		16'h4000, 16'hc000, 16'h5555, 16'haaaa, 16'h8000, 16'h6000, 16'hffff
	};

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [ABITS-1:0] roll_angle;
	logic signed [ABITS-1:0] pitch_angle;
	logic signed [ABITS-1:0] yaw_angle;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [RBITS-1:0] quat_w;
	logic signed [RBITS-1:0] quat_x;
	logic signed [RBITS-1:0] quat_y;
	logic signed [RBITS-1:0] quat_z;

	int errors;
	int pending;
	int checked;
	int sent;
	bit steady;

	euler_to_quaternion dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.quat_w      (quat_w),
		.quat_x      (quat_x),
		.quat_y      (quat_y),
		.quat_z      (quat_z)
	);

	euler_to_quaternion_check check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.quat_w      (quat_w),
		.quat_x      (quat_x),
		.quat_y      (quat_y),
		.quat_z      (quat_z),
		.errors      (errors),
		.pending     (pending),
		.checked     (checked)
	);

	// 12 ns clock
	always begin
		#6 clk = ~clk;
	end

	// random receiver stalls, none during the steady stretch
	always @(posedge clk) begin
		if (!arst_n || steady)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 26);
	end

	// run limit
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("euler_to_quaternion_test failed");
		$finish;
	end

	// random angle: uniform, near a multiple of an eighth turn, or at an extreme
	function automatic logic [15:0] pick_angle();
		int unsigned mode;
		mode = $urandom_range(99);
		if (mode < 60)
			return 16'($urandom);
		else if (mode < 85)
			return 16'($urandom_range(7) * 8192 + $urandom_range(8) - 4);
		else
			case ($urandom_range(3))
				0: return 16'h8000;
				1: return 16'h7fff;
				2: return 16'h0000;
				default: return 16'h8001;
			endcase
	endfunction

	// one angle beat, with random idle cycles ahead of it outside the steady stretch
	task automatic send_angles(input logic [15:0] r, input logic [15:0] p,
			input logic [15:0] yw);
		while (!steady && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		roll_angle  <= r;
		pitch_angle <= p;
		yaw_angle   <= yw;
		// stall is settled at the falling edge and holds until the next rising edge
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		roll_angle = '0;
		pitch_angle = '0;
		yaw_angle = '0;
		steady = 1'b0;
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED; i++)
			send_angles(DIR_ROLL[i], DIR_PITCH[i], DIR_YAW[i]);

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			steady = (i >= 250 && i < 400);
			send_angles(pick_angle(), pick_angle(), pick_angle());
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// drain the pipeline, then give stray beats a chance to show up
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d angle triples (directed extremes, quarter turns, random)", sent);
		$display("checked %0d quaternions, both channels idled at random with one gap-free stretch",
			checked);
		if (errors == 0 && pending == 0)
			$display("euler_to_quaternion_test passed");
		else
			$display("euler_to_quaternion_test failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/e2q_pkg.sv
rtl/e2q_cordic_cell.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
sim/euler_to_quaternion_check.sv
sim/euler_to_quaternion_test.sv
